[design/sgb_pkg.sv]
package sgb_pkg;

    // Framebuffer geometry; both sizes are powers of two so that wrapping is truncation
    localparam int ROW_STRIDE = 4096;
    localparam int FB_ROWS    = 1024;
    localparam int COL_W      = $clog2(ROW_STRIDE);
    localparam int ROW_W      = $clog2(FB_ROWS);

    // Glyph geometry
    localparam int MAX_SCALE   = 4;
    localparam int GLYPH_ROWS  = 14;
    localparam int SCALE_W     = 3;
    localparam int NROWS_W     = 6;
    localparam int NPIX_W      = 6;
    localparam int SPAN_W      = 14;
    localparam int GROW_W      = 4;
    localparam int SUB_W       = 2;
    localparam int MASK_W      = 32;

    // Font store
    localparam int FONT_DEPTH = 4096;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int FONT_DW    = 8;

    // Operations and special codes
    localparam logic       OP_FONT_WRITE = 1'b0;
    localparam logic       OP_DRAW       = 1'b1;
    localparam logic [7:0] CTRL_CODE_MAX = 8'h1f;

    // Register map, word index
    localparam logic [2:0] REG_SCALE_X    = 3'd0;
    localparam logic [2:0] REG_SCALE_Y    = 3'd1;
    localparam logic [2:0] REG_BG_COLOR   = 3'd2;
    localparam logic [2:0] REG_BG_ENABLE  = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd5;
    localparam int         PADDR_W        = 5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAW
    } state_t;

    // Saturate a scale setting at the largest supported factor
    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        r = (s > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : s;
        return r;
    endfunction

    // Stretch one font byte across the segment; bit 7 is the leftmost pixel
    function automatic logic [MASK_W-1:0] expand_row(input logic [7:0] bits,
                                                     input logic [SCALE_W-1:0] sx);
        logic [MASK_W-1:0] m;
        int b;
        m = '0;
        for (int p = 0; p < MASK_W; p++)
        begin
            case (sx)
                3'd0:    b = 2 * p;
                3'd1:    b = p;
                3'd2:    b = p / 2;
                3'd3:    b = p / 3;
                default: b = p / 4;
            endcase
            if (b < 8)
            begin
                m[p] = bits[3'(7 - b)];
            end
        end
        return m;
    endfunction

endpackage

[design/sgb_if.sv]
// Draw / font-write request channel
interface sgb_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [sgb_pkg::FONT_AW-1:0]     font_address;
    logic [sgb_pkg::FONT_DW-1:0]     font_data;
    logic [7:0]                      char_code;
    logic [7:0]                      char_index;
    logic                            vertical;
    logic [11:0]                     pos_x;
    logic [9:0]                      pos_y;
    logic [7:0]                      fg_color;

    modport source (output valid, operation, font_address, font_data, char_code,
                    char_index, vertical, pos_x, pos_y, fg_color,
                    input ready);
    modport sink   (input valid, operation, font_address, font_data, char_code,
                    char_index, vertical, pos_x, pos_y, fg_color,
                    output ready);
endinterface

// Row segment channel
interface sgb_out_if;
    logic                            valid;
    logic                            ready;
    logic [sgb_pkg::ROW_W-1:0]       row;
    logic [sgb_pkg::COL_W-1:0]       column;
    logic [sgb_pkg::MASK_W-1:0]      pixel_mask;
    logic [sgb_pkg::NPIX_W-1:0]      pixel_count;
    logic [7:0]                      write_fg_color;
    logic                            background_write;
    logic                            last;

    modport source (output valid, row, column, pixel_mask, pixel_count, write_fg_color,
                    background_write, last,
                    input ready);
    modport sink   (input valid, row, column, pixel_mask, pixel_count, write_fg_color,
                    background_write, last,
                    output ready);
endinterface

[design/scaled_glyph_blitter_unit.sv]
// Font write: done at the transfer, no result. Vertical control code: accepted, no result.
// Draw: the transfer starts the first font read, then one row segment per cycle is
// loaded while the sink keeps up (one font read per output row from the glyph store).
// A draw emits one segment per row, rows = 14*scale_y (7 at half size), up to 56.
// Reset (rst_n low, asynchronous) resets configuration, sequencer and output valid;
// data registers and the font store are left as is; unwritten entries read undefined.
module scaled_glyph_blitter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sgb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    sgb_in_if.sink                        item,
    sgb_out_if.source                     result
);

    // Configuration registers
    logic [2:0]                  scale_x_reg;
    logic [2:0]                  scale_y_reg;
    logic [7:0]                  bg_color_reg;
    logic                        bg_enable_reg;
    logic [11:0]                 origin_x_reg;
    logic [9:0]                  origin_y_reg;
    logic                        cfg_write;
    logic [2:0]                  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg   <= 3'd1;
            scale_y_reg   <= 3'd1;
            bg_color_reg  <= '0;
            bg_enable_reg <= 1'b0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sgb_pkg::REG_SCALE_X:   scale_x_reg   <= pwdata[2:0];
                sgb_pkg::REG_SCALE_Y:   scale_y_reg   <= pwdata[2:0];
                sgb_pkg::REG_BG_COLOR:  bg_color_reg  <= pwdata[7:0];
                sgb_pkg::REG_BG_ENABLE: bg_enable_reg <= pwdata[0];
                sgb_pkg::REG_ORIGIN_X:  origin_x_reg  <= pwdata[11:0];
                sgb_pkg::REG_ORIGIN_Y:  origin_y_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_index)
            sgb_pkg::REG_SCALE_X:   prdata = 32'(scale_x_reg);
            sgb_pkg::REG_SCALE_Y:   prdata = 32'(scale_y_reg);
            sgb_pkg::REG_BG_COLOR:  prdata = 32'(bg_color_reg);
            sgb_pkg::REG_BG_ENABLE: prdata = 32'(bg_enable_reg);
            sgb_pkg::REG_ORIGIN_X:  prdata = 32'(origin_x_reg);
            sgb_pkg::REG_ORIGIN_Y:  prdata = 32'(origin_y_reg);
            default:                prdata = '0;
        endcase
    end

    // Placement of the character, worked out at the request transfer
    logic [sgb_pkg::SCALE_W-1:0] sx_calc;
    logic [sgb_pkg::SCALE_W-1:0] sy_calc;
    logic [sgb_pkg::NPIX_W-1:0]  npix_calc;
    logic [sgb_pkg::NROWS_W-1:0] nrows_calc;
    logic [sgb_pkg::SPAN_W-1:0]  span_calc;
    logic [sgb_pkg::COL_W-1:0]   hoff_calc;
    logic [sgb_pkg::ROW_W-1:0]   voff_calc;
    logic [sgb_pkg::COL_W-1:0]   left_calc;
    logic [sgb_pkg::ROW_W-1:0]   top_calc;

    always_comb
    begin
        sx_calc    = sgb_pkg::clamp_scale(scale_x_reg);
        sy_calc    = sgb_pkg::clamp_scale(scale_y_reg);
        npix_calc  = (sx_calc != '0) ? sgb_pkg::NPIX_W'(8 * sx_calc)
                                     : sgb_pkg::NPIX_W'(4);
        nrows_calc = (sy_calc != '0) ? sgb_pkg::NROWS_W'(sgb_pkg::GLYPH_ROWS * sy_calc)
                                     : sgb_pkg::NROWS_W'(sgb_pkg::GLYPH_ROWS / 2);
        // horizontal strings step by segment width, vertical ones by glyph height
        if (!item.vertical)
        begin
            span_calc = sgb_pkg::SPAN_W'(item.char_index * npix_calc);
            hoff_calc = (sx_calc != '0) ? sgb_pkg::COL_W'(7 * sx_calc) : sgb_pkg::COL_W'(4);
            voff_calc = (sy_calc != '0) ? sgb_pkg::ROW_W'(4 * sy_calc) : sgb_pkg::ROW_W'(2);
            left_calc = sgb_pkg::COL_W'(item.pos_x) + sgb_pkg::COL_W'(origin_x_reg)
                      - hoff_calc + sgb_pkg::COL_W'(span_calc);
            top_calc  = sgb_pkg::ROW_W'(item.pos_y) + sgb_pkg::ROW_W'(origin_y_reg)
                      - voff_calc;
        end
        else
        begin
            span_calc = sgb_pkg::SPAN_W'(item.char_index * nrows_calc);
            hoff_calc = (sx_calc != '0) ? sgb_pkg::COL_W'(4 * sx_calc) : sgb_pkg::COL_W'(2);
            voff_calc = (sy_calc != '0) ? sgb_pkg::ROW_W'(7 * sy_calc) : sgb_pkg::ROW_W'(4);
            left_calc = sgb_pkg::COL_W'(item.pos_x) + sgb_pkg::COL_W'(origin_x_reg)
                      - hoff_calc;
            top_calc  = sgb_pkg::ROW_W'(item.pos_y) + sgb_pkg::ROW_W'(origin_y_reg)
                      - voff_calc + sgb_pkg::ROW_W'(span_calc);
        end
    end

    // Sequencer state
    sgb_pkg::state_t              state_reg, state_next;
    logic [sgb_pkg::NROWS_W-1:0]  r_reg, r_next;
    logic [sgb_pkg::SUB_W-1:0]    sub_reg, sub_next;
    logic [sgb_pkg::GROW_W-1:0]   grow_reg, grow_next;
    logic [7:0]                   code_reg, code_next;
    logic                         start;
    logic                         out_load;
    logic                         out_free;
    logic                         font_we;
    logic                         item_ready;

    // Draw parameters held for the character
    logic [sgb_pkg::SCALE_W-1:0]  sx_reg, sy_reg;
    logic [sgb_pkg::NROWS_W-1:0]  nrows_reg;
    logic [sgb_pkg::NPIX_W-1:0]   npix_reg;
    logic [sgb_pkg::COL_W-1:0]    left_reg;
    logic [sgb_pkg::ROW_W-1:0]    row_cur_reg;
    logic [7:0]                   fg_reg;

    // Output register
    logic                         out_valid_reg;
    logic [sgb_pkg::ROW_W-1:0]    out_row_reg;
    logic [sgb_pkg::COL_W-1:0]    out_col_reg;
    logic [sgb_pkg::MASK_W-1:0]   out_mask_reg;
    logic [sgb_pkg::NPIX_W-1:0]   out_count_reg;
    logic [7:0]                   out_fg_reg;
    logic                         out_bgw_reg;
    logic                         out_last_reg;

    logic [sgb_pkg::FONT_DW-1:0]  font_rdata;
    logic                         row_is_last;

    assign item_ready  = (state_reg == sgb_pkg::ST_IDLE);
    assign item.ready  = item_ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign font_we     = item.valid && item_ready && (item.operation == sgb_pkg::OP_FONT_WRITE);
    assign row_is_last = (r_reg == nrows_reg - sgb_pkg::NROWS_W'(1));

    // Next state and row counters; the font address follows the next row so that
    // the registered read lines up with the row being emitted
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        sub_next   = sub_reg;
        grow_next  = grow_reg;
        code_next  = code_reg;
        start      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            sgb_pkg::ST_IDLE:
            begin
                if (item.valid && (item.operation == sgb_pkg::OP_DRAW)
                    && !(item.vertical && (item.char_code <= sgb_pkg::CTRL_CODE_MAX)))
                begin
                    start      = 1'b1;
                    state_next = sgb_pkg::ST_DRAW;
                    r_next     = '0;
                    sub_next   = '0;
                    grow_next  = '0;
                    code_next  = item.char_code;
                end
            end
            sgb_pkg::ST_DRAW:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (row_is_last)
                    begin
                        state_next = sgb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        r_next = r_reg + sgb_pkg::NROWS_W'(1);
                        if (sy_reg == '0)
                        begin
                            grow_next = grow_reg + sgb_pkg::GROW_W'(2);
                        end
                        else if (sgb_pkg::SCALE_W'(sub_reg) == sy_reg - sgb_pkg::SCALE_W'(1))
                        begin
                            sub_next  = '0;
                            grow_next = grow_reg + sgb_pkg::GROW_W'(1);
                        end
                        else
                        begin
                            sub_next = sub_reg + sgb_pkg::SUB_W'(1);
                        end
                    end
                end
            end
            default: state_next = sgb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgb_pkg::ST_IDLE;
            r_reg     <= '0;
            sub_reg   <= '0;
            grow_reg  <= '0;
            code_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            sub_reg   <= sub_next;
            grow_reg  <= grow_next;
            code_reg  <= code_next;
        end
    end

    // Per-character parameters and current framebuffer row
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sx_reg      <= sx_calc;
            sy_reg      <= sy_calc;
            nrows_reg   <= nrows_calc;
            npix_reg    <= npix_calc;
            left_reg    <= left_calc;
            row_cur_reg <= top_calc;
            fg_reg      <= item.fg_color;
        end
        else if (out_load)
        begin
            row_cur_reg <= row_cur_reg + sgb_pkg::ROW_W'(1);
        end
    end

    // Glyph store
    sgb_ram #(
        .WIDTH (sgb_pkg::FONT_DW),
        .DEPTH (sgb_pkg::FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (font_we),
        .waddr (item.font_address),
        .wdata (item.font_data),
        .raddr ({code_next, grow_next}),
        .rdata (font_rdata)
    );

    // Output register: loads when empty or when the held segment transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= row_cur_reg;
            out_col_reg   <= left_reg;
            out_mask_reg  <= sgb_pkg::expand_row(font_rdata, sx_reg);
            out_count_reg <= npix_reg;
            out_fg_reg    <= fg_reg;
            out_bgw_reg   <= bg_enable_reg;
            out_last_reg  <= row_is_last;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.row              = out_row_reg;
    assign result.column           = out_col_reg;
    assign result.pixel_mask       = out_mask_reg;
    assign result.pixel_count      = out_count_reg;
    assign result.write_fg_color   = out_fg_reg;
    assign result.background_write = out_bgw_reg;
    assign result.last             = out_last_reg;

    // A segment that is not the last one only stands while the character is drawing
    a_mid_row_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg == sgb_pkg::ST_DRAW))
        else $error("non-final segment held outside a draw");

    // Consecutive segments of one character step down by one row
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg && !out_last_reg)
            |-> (row_cur_reg == out_row_reg + sgb_pkg::ROW_W'(1)))
        else $error("segment row did not advance by one");

    // Segment width does not change within a character
    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg && !out_last_reg) |=> $stable(out_count_reg))
        else $error("segment width changed within a character");

endmodule

[design/sgb_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle
module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
